FILE: design/gfe_pkg.sv
// ============================================================================
// gfe_pkg
// Shared types and constants for the grid fire escape search block.
// ============================================================================
package gfe_pkg;

    localparam int DEF_MAX_ROWS = 128;
    localparam int DEF_MAX_COLS = 128;

    localparam int CFG_W    = 8;
    localparam int CFG_IDXW = 1;
    localparam logic [CFG_IDXW-1:0] CFG_NUM_ROWS = 1'd0;
    localparam logic [CFG_IDXW-1:0] CFG_NUM_COLS = 1'd1;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_OPEN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUNNER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd3;

    localparam int OUT_TIME_W = 15;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SCAN,
        S_FPOP,
        S_FWAIT,
        S_FNB,
        S_FCHK,
        S_RPOP,
        S_RWAIT,
        S_RNB,
        S_RCHK,
        S_DONE
    } t_state;

endpackage

FILE: design/gfe_if.sv
// ============================================================================
// gfe_if
// Valid/ready channels for grid cell words and search result words.
// ============================================================================
interface gfe_in_if;
    import gfe_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] cell_kind;
    logic              last_cell;
    modport source (output valid, cell_kind, last_cell, input ready);
    modport sink   (input valid, cell_kind, last_cell, output ready);
endinterface

interface gfe_out_if;
    import gfe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  escaped;
    logic [OUT_TIME_W-1:0] exit_time;
    modport source (output valid, escaped, exit_time, input ready);
    modport sink   (input valid, escaped, exit_time, output ready);
endinterface

FILE: design/grid_fire_escape_bfs.sv
// ============================================================================
// grid_fire_escape_bfs
// Loads a grid one cell per cycle, floods fire from all sources, then floods
// the runner and reports the escape time through the border.
// ============================================================================
// Cells are taken one word per cycle and written straight into the cell
// memory. The word that marks the last cell starts the search and no further
// cell is taken until the result word has been delivered. The search first
// sweeps all rows*cols cells once, which clears the time memories and queues
// the sources. Each dequeued cell then reads its queue entry and visits its
// neighbours in turn; a neighbour inside the grid is read and then checked,
// as all time, kind and queue memories have a single read port.
module grid_fire_escape_bfs #(
    parameter int MAX_ROWS = gfe_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gfe_pkg::DEF_MAX_COLS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gfe_pkg::CFG_IDXW-1:0] i_cfg_idx,
    input  logic [gfe_pkg::CFG_W-1:0]    i_cfg_data,
    gfe_in_if.sink                       i_in,
    gfe_out_if.source                    o_out
);
    import gfe_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = AW + 1;
    localparam int TW    = CNTW;
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int DRW   = $clog2(MAX_ROWS + 1);
    localparam int DCW   = $clog2(MAX_COLS + 1);
    localparam int CRW   = DRW > CFG_W ? DRW : CFG_W;
    localparam int CCW   = DCW > CFG_W ? DCW : CFG_W;
    localparam int QW    = TW + RW + CW + AW;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_rows, n_rows, r_cols, n_cols;
    logic [CNTW-1:0]  r_lpos, n_lpos;
    logic [DRW-1:0]   r_srows, n_srows;
    logic [DCW-1:0]   r_scols, n_scols;
    logic [CNTW-1:0]  r_stot, n_stot;
    logic [CNTW-1:0]  r_idx, n_idx;
    logic [RW-1:0]    r_sr, n_sr;
    logic [CW-1:0]    r_sc, n_sc;
    logic             r_pv, n_pv;
    logic [AW-1:0]    r_pa, n_pa;
    logic [RW-1:0]    r_pr, n_pr;
    logic [CW-1:0]    r_pc, n_pc;
    logic [CNTW-1:0]  r_fh, n_fh, r_ft, n_ft, r_rh, n_rh, r_rt, n_rt;
    logic [TW-1:0]    r_et, n_et;
    logic [RW-1:0]    r_er, n_er;
    logic [CW-1:0]    r_ec, n_ec;
    logic [AW-1:0]    r_ep, n_ep;
    t_dir             r_k, n_k;
    logic [AW-1:0]    r_q, n_q;
    logic [RW-1:0]    r_nr, n_nr;
    logic [CW-1:0]    r_nc, n_nc;
    logic             r_ovld, n_ovld;
    logic             r_oesc, n_oesc;
    logic [OUT_TIME_W-1:0] r_otime, n_otime;

    logic [CRW-1:0]  rows_ext;
    logic [CCW-1:0]  cols_ext;
    logic [DRW-1:0]  rows_c;
    logic [DCW-1:0]  cols_c;
    logic [CNTW-1:0] total_c;

    logic              cell_we;
    logic [AW-1:0]     cell_waddr, cell_raddr;
    logic [KIND_W-1:0] cell_wdata, cell_rdata;
    logic              fire_we;
    logic [AW-1:0]     fire_waddr, fire_raddr;
    logic [TW-1:0]     fire_wdata, fire_rdata;
    logic              run_we;
    logic [AW-1:0]     run_waddr, run_raddr;
    logic [TW-1:0]     run_wdata, run_rdata;
    logic              fq_we, rq_we;
    logic [AW-1:0]     fq_waddr, fq_raddr, rq_waddr, rq_raddr;
    logic [QW-1:0]     fq_wdata, fq_rdata, rq_wdata, rq_rdata;

    logic          nb_in;
    logic [AW-1:0] nb_q;
    logic [RW-1:0] nb_r;
    logic [CW-1:0] nb_c;
    logic [TW-1:0] t_next;
    logic [TW-1:0] pop_t;
    logic [RW-1:0] pop_r;
    logic [CW-1:0] pop_c;
    logic [AW-1:0] pop_p;

    gfe_ram #(.WIDTH(KIND_W), .DEPTH(CELLS)) u_cell_ram (
        .i_clk(i_clk), .i_we(cell_we), .i_waddr(cell_waddr), .i_wdata(cell_wdata),
        .i_raddr(cell_raddr), .o_rdata(cell_rdata)
    );
    gfe_ram #(.WIDTH(TW), .DEPTH(CELLS)) u_fire_ram (
        .i_clk(i_clk), .i_we(fire_we), .i_waddr(fire_waddr), .i_wdata(fire_wdata),
        .i_raddr(fire_raddr), .o_rdata(fire_rdata)
    );
    gfe_ram #(.WIDTH(TW), .DEPTH(CELLS)) u_run_ram (
        .i_clk(i_clk), .i_we(run_we), .i_waddr(run_waddr), .i_wdata(run_wdata),
        .i_raddr(run_raddr), .o_rdata(run_rdata)
    );
    gfe_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_fq_ram (
        .i_clk(i_clk), .i_we(fq_we), .i_waddr(fq_waddr), .i_wdata(fq_wdata),
        .i_raddr(fq_raddr), .o_rdata(fq_rdata)
    );
    gfe_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_rq_ram (
        .i_clk(i_clk), .i_we(rq_we), .i_waddr(rq_waddr), .i_wdata(rq_wdata),
        .i_raddr(rq_raddr), .o_rdata(rq_rdata)
    );

    always_comb begin
        rows_ext = CRW'(r_rows);
        cols_ext = CCW'(r_cols);
        if (rows_ext == '0) begin
            rows_c = DRW'(1);
        end else if (rows_ext > CRW'(MAX_ROWS)) begin
            rows_c = DRW'(MAX_ROWS);
        end else begin
            rows_c = DRW'(rows_ext);
        end
        if (cols_ext == '0) begin
            cols_c = DCW'(1);
        end else if (cols_ext > CCW'(MAX_COLS)) begin
            cols_c = DCW'(MAX_COLS);
        end else begin
            cols_c = DCW'(cols_ext);
        end
        total_c = CNTW'(rows_c * cols_c);
    end

    assign t_next = r_et + TW'(1);
    assign {pop_t, pop_r, pop_c, pop_p} = (r_state == S_RWAIT) ? rq_rdata : fq_rdata;

    always_comb begin
        nb_in = 1'b0;
        nb_q  = r_ep;
        nb_r  = r_er;
        nb_c  = r_ec;
        case (r_k)
            DIR_UP: begin
                nb_in = r_er != '0;
                nb_q  = r_ep - AW'(r_scols);
                nb_r  = r_er - RW'(1);
            end
            DIR_DOWN: begin
                nb_in = DRW'(r_er) != r_srows - DRW'(1);
                nb_q  = r_ep + AW'(r_scols);
                nb_r  = r_er + RW'(1);
            end
            DIR_LEFT: begin
                nb_in = r_ec != '0;
                nb_q  = r_ep - AW'(1);
                nb_c  = r_ec - CW'(1);
            end
            DIR_RIGHT: begin
                nb_in = DCW'(r_ec) != r_scols - DCW'(1);
                nb_q  = r_ep + AW'(1);
                nb_c  = r_ec + CW'(1);
            end
            default: begin
                nb_in = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_rows  <= CFG_W'(1);
            r_cols  <= CFG_W'(1);
            r_lpos  <= '0;
            r_srows <= DRW'(1);
            r_scols <= DCW'(1);
            r_stot  <= CNTW'(1);
            r_idx   <= '0;
            r_sr    <= '0;
            r_sc    <= '0;
            r_pv    <= 1'b0;
            r_pa    <= '0;
            r_pr    <= '0;
            r_pc    <= '0;
            r_fh    <= '0;
            r_ft    <= '0;
            r_rh    <= '0;
            r_rt    <= '0;
            r_et    <= '0;
            r_er    <= '0;
            r_ec    <= '0;
            r_ep    <= '0;
            r_k     <= DIR_UP;
            r_q     <= '0;
            r_nr    <= '0;
            r_nc    <= '0;
            r_ovld  <= 1'b0;
            r_oesc  <= 1'b0;
            r_otime <= '0;
        end else begin
            r_state <= n_state;
            r_rows  <= n_rows;
            r_cols  <= n_cols;
            r_lpos  <= n_lpos;
            r_srows <= n_srows;
            r_scols <= n_scols;
            r_stot  <= n_stot;
            r_idx   <= n_idx;
            r_sr    <= n_sr;
            r_sc    <= n_sc;
            r_pv    <= n_pv;
            r_pa    <= n_pa;
            r_pr    <= n_pr;
            r_pc    <= n_pc;
            r_fh    <= n_fh;
            r_ft    <= n_ft;
            r_rh    <= n_rh;
            r_rt    <= n_rt;
            r_et    <= n_et;
            r_er    <= n_er;
            r_ec    <= n_ec;
            r_ep    <= n_ep;
            r_k     <= n_k;
            r_q     <= n_q;
            r_nr    <= n_nr;
            r_nc    <= n_nc;
            r_ovld  <= n_ovld;
            r_oesc  <= n_oesc;
            r_otime <= n_otime;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rows  = r_rows;
        n_cols  = r_cols;
        n_lpos  = r_lpos;
        n_srows = r_srows;
        n_scols = r_scols;
        n_stot  = r_stot;
        n_idx   = r_idx;
        n_sr    = r_sr;
        n_sc    = r_sc;
        n_pv    = 1'b0;
        n_pa    = r_idx[AW-1:0];
        n_pr    = r_sr;
        n_pc    = r_sc;
        n_fh    = r_fh;
        n_ft    = r_ft;
        n_rh    = r_rh;
        n_rt    = r_rt;
        n_et    = r_et;
        n_er    = r_er;
        n_ec    = r_ec;
        n_ep    = r_ep;
        n_k     = r_k;
        n_q     = r_q;
        n_nr    = r_nr;
        n_nc    = r_nc;
        n_ovld  = r_ovld;
        n_oesc  = r_oesc;
        n_otime = r_otime;

        cell_we    = 1'b0;
        cell_waddr = r_lpos[AW-1:0];
        cell_wdata = i_in.cell_kind;
        cell_raddr = nb_q;
        fire_we    = 1'b0;
        fire_waddr = r_q;
        fire_wdata = t_next;
        fire_raddr = nb_q;
        run_we     = 1'b0;
        run_waddr  = r_q;
        run_wdata  = t_next;
        run_raddr  = nb_q;
        fq_we      = 1'b0;
        fq_waddr   = r_ft[AW-1:0];
        fq_wdata   = {t_next, r_nr, r_nc, r_q};
        fq_raddr   = r_fh[AW-1:0];
        rq_we      = 1'b0;
        rq_waddr   = r_rt[AW-1:0];
        rq_wdata   = {t_next, r_nr, r_nc, r_q};
        rq_raddr   = r_rh[AW-1:0];

        i_in.ready = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_ROWS: n_rows = i_cfg_data;
                CFG_NUM_COLS: n_cols = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_LOAD: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (r_lpos < total_c) begin
                        cell_we = 1'b1;
                        n_lpos  = r_lpos + CNTW'(1);
                    end
                    if (i_in.last_cell) begin
                        n_srows = rows_c;
                        n_scols = cols_c;
                        n_stot  = total_c;
                        n_idx   = '0;
                        n_sr    = '0;
                        n_sc    = '0;
                        n_fh    = '0;
                        n_ft    = '0;
                        n_rh    = '0;
                        n_rt    = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cell_raddr = r_idx[AW-1:0];
                if (r_idx < r_stot) begin
                    n_pv  = 1'b1;
                    n_idx = r_idx + CNTW'(1);
                    if (DCW'(r_sc) == r_scols - DCW'(1)) begin
                        n_sc = '0;
                        n_sr = r_sr + RW'(1);
                    end else begin
                        n_sc = r_sc + CW'(1);
                    end
                end else if (!r_pv) begin
                    n_state = S_FPOP;
                end
                if (r_pv) begin
                    fire_we    = 1'b1;
                    fire_waddr = r_pa;
                    fire_wdata = (cell_rdata == KIND_FIRE) ? TW'(1) : '0;
                    run_we     = 1'b1;
                    run_waddr  = r_pa;
                    run_wdata  = (cell_rdata == KIND_RUNNER) ? TW'(1) : '0;
                    fq_wdata   = {TW'(1), r_pr, r_pc, r_pa};
                    rq_wdata   = {TW'(1), r_pr, r_pc, r_pa};
                    if (cell_rdata == KIND_FIRE) begin
                        fq_we = 1'b1;
                        n_ft  = r_ft + CNTW'(1);
                    end
                    if (cell_rdata == KIND_RUNNER) begin
                        rq_we = 1'b1;
                        n_rt  = r_rt + CNTW'(1);
                    end
                end
            end
            S_FPOP: begin
                if (r_fh == r_ft) begin
                    n_state = S_RPOP;
                end else begin
                    n_fh    = r_fh + CNTW'(1);
                    n_state = S_FWAIT;
                end
            end
            S_FWAIT: begin
                n_et    = pop_t;
                n_er    = pop_r;
                n_ec    = pop_c;
                n_ep    = pop_p;
                n_k     = DIR_UP;
                n_state = S_FNB;
            end
            S_FNB: begin
                n_q  = nb_q;
                n_nr = nb_r;
                n_nc = nb_c;
                if (nb_in) begin
                    n_state = S_FCHK;
                end else if (r_k == DIR_RIGHT) begin
                    n_state = S_FPOP;
                end else begin
                    n_k = t_dir'(r_k + 2'd1);
                end
            end
            S_FCHK: begin
                if (cell_rdata != KIND_WALL && fire_rdata == '0) begin
                    fire_we = 1'b1;
                    fq_we   = 1'b1;
                    n_ft    = r_ft + CNTW'(1);
                end
                if (r_k == DIR_RIGHT) begin
                    n_state = S_FPOP;
                end else begin
                    n_k     = t_dir'(r_k + 2'd1);
                    n_state = S_FNB;
                end
            end
            S_RPOP: begin
                if (r_rh == r_rt) begin
                    n_ovld  = 1'b1;
                    n_oesc  = 1'b0;
                    n_otime = '0;
                    n_state = S_DONE;
                end else begin
                    n_rh    = r_rh + CNTW'(1);
                    n_state = S_RWAIT;
                end
            end
            S_RWAIT: begin
                n_et = pop_t;
                n_er = pop_r;
                n_ec = pop_c;
                n_ep = pop_p;
                n_k  = DIR_UP;
                if (pop_r == '0 || DRW'(pop_r) == r_srows - DRW'(1) ||
                    pop_c == '0 || DCW'(pop_c) == r_scols - DCW'(1)) begin
                    n_ovld  = 1'b1;
                    n_oesc  = pop_t != '0;
                    n_otime = OUT_TIME_W'(pop_t);
                    n_state = S_DONE;
                end else begin
                    n_state = S_RNB;
                end
            end
            S_RNB: begin
                n_q     = nb_q;
                n_nr    = nb_r;
                n_nc    = nb_c;
                n_state = S_RCHK;
            end
            S_RCHK: begin
                if (cell_rdata != KIND_WALL && run_rdata == '0 &&
                    !(fire_rdata != '0 && fire_rdata <= t_next)) begin
                    run_we = 1'b1;
                    rq_we  = 1'b1;
                    n_rt   = r_rt + CNTW'(1);
                end
                if (r_k == DIR_RIGHT) begin
                    n_state = S_RPOP;
                end else begin
                    n_k     = t_dir'(r_k + 2'd1);
                    n_state = S_RNB;
                end
            end
            S_DONE: begin
                if (o_out.ready) begin
                    n_ovld  = 1'b0;
                    n_lpos  = '0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_out.valid     = r_ovld;
    assign o_out.escaped   = r_oesc;
    assign o_out.exit_time = r_otime;

`ifndef ASSERT_OFF
    a_fire_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fh <= r_ft)
        else $error("fire queue head passed its tail");
    a_run_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rh <= r_rt)
        else $error("runner queue head passed its tail");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ft <= r_stot && r_rt <= r_stot)
        else $error("search queue grew beyond the grid");
    a_result_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> r_state == S_DONE)
        else $error("result word shown outside the result state");
    a_no_load_during_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !r_ovld)
        else $error("cell word taken while a result is pending");
`endif
endmodule

FILE: design/gfe_ram.sv
// ============================================================================
// gfe_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module gfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
